/* hdl/ows_pkg.sv */
// Shared types and constants for the one-wire ROM search engine.
package ows_pkg;

  // Counter width: bit positions 1..64 and the value 64 itself
  localparam int unsigned CNT_W = 7;
  localparam int unsigned ROM_W = 64;

  localparam logic [7:0] SEARCH_NORMAL_BYTE = 8'hF0;
  localparam logic [7:0] SEARCH_COND_BYTE   = 8'hEC;
  localparam logic [7:0] TARGET_FAMILY_RST  = 8'd45;
  // Zero branches below this position lie in the family byte
  localparam logic [CNT_W-1:0] FAMILY_LIMIT = 7'd9;

  typedef enum logic [1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_PAIR   = 2'd1,
    CMD_RESET  = 2'd2,
    CMD_TARGET = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CMD   = 3'd0,
    ST_WRITE = 3'd1,
    ST_FOUND = 3'd2,
    ST_FAIL  = 3'd3,
    ST_ACK   = 3'd4,
    ST_IGN   = 3'd5
  } status_t;

  typedef struct packed {
    cmd_t cmd;
    logic presence;
    logic normal_search;
    logic id_bit;
    logic complement_bit;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic             write_valid;
    logic             direction_bit;
    logic [7:0]       command_byte;
    logic [ROM_W-1:0] rom_id;
    logic             last_device;
    logic [CNT_W-1:0] family_discrepancy;
  } out_item_t;

  // Handshake between the input register and the search core
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

endpackage

/* hdl/ows_in_if.sv */
// Input channel: one search step per transfer.
interface ows_in_if;
  logic              valid;
  logic              ready;
  ows_pkg::cmd_t     cmd;
  logic              presence;
  logic              normal_search;
  logic              id_bit;
  logic              complement_bit;

  modport source (output valid, cmd, presence, normal_search, id_bit, complement_bit,
                  input ready);
  modport sink   (input valid, cmd, presence, normal_search, id_bit, complement_bit,
                  output ready);
endinterface

/* hdl/ows_out_if.sv */
// Result channel: one result per accepted step.
interface ows_out_if;
  logic                           valid;
  logic                           ready;
  ows_pkg::status_t               status;
  logic                           write_valid;
  logic                           direction_bit;
  logic [7:0]                     command_byte;
  logic [ows_pkg::ROM_W-1:0]      rom_id;
  logic                           last_device;
  logic [ows_pkg::CNT_W-1:0]      family_discrepancy;

  modport source (output valid, status, write_valid, direction_bit, command_byte, rom_id,
                  last_device, family_discrepancy, input ready);
  modport sink   (input valid, status, write_valid, direction_bit, command_byte, rom_id,
                  last_device, family_discrepancy, output ready);
endinterface

/* hdl/ows_in_reg.sv */
// Input register: captures one step and holds it until the core takes it.
module ows_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  ows_pkg::in_item_t in_item,
  output logic              in_ready,
  input  logic              take,
  output ows_pkg::stage_t   stage
);

  logic              valid_r;
  ows_pkg::in_item_t item_r;

  assign in_ready = !valid_r || take;
  assign stage    = '{valid: valid_r, item: item_r};

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Payload, loaded on each transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

/* hdl/ows_core.sv */
// Search core: enumeration state and the combinational step logic.
module ows_core #(
  parameter int unsigned ID_BITS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ows_pkg::stage_t     stage,
  input  logic                out_free,
  input  logic [7:0]          target_family,
  output logic                fire,
  output ows_pkg::out_item_t  res
);

  localparam int unsigned POS_W = $clog2(ID_BITS);
  localparam logic [ows_pkg::CNT_W-1:0] LAST_POS = ows_pkg::CNT_W'(ID_BITS);
  localparam logic [ows_pkg::CNT_W-1:0] ONE      = ows_pkg::CNT_W'(1);

  logic [ID_BITS-1:0]       rom_r,  rom_nxt;
  logic [ows_pkg::CNT_W-1:0] ld_r,  ld_nxt;
  logic [ows_pkg::CNT_W-1:0] fm_r,  fm_nxt;
  logic                      done_r, done_nxt;
  logic [ows_pkg::CNT_W-1:0] bi_r,  bi_nxt;
  logic [ows_pkg::CNT_W-1:0] zm_r,  zm_nxt;
  logic                      srch_r, srch_nxt;

  assign fire = stage.valid && out_free;

  // Step logic
  always_comb begin
    logic [POS_W-1:0]          pos;
    logic                      dir;
    logic [ID_BITS-1:0]        rom_t;
    logic [ows_pkg::CNT_W-1:0] zm_t;
    logic [ows_pkg::CNT_W-1:0] fm_t;
    logic                      done_t;

    rom_nxt  = rom_r;
    ld_nxt   = ld_r;
    fm_nxt   = fm_r;
    done_nxt = done_r;
    bi_nxt   = bi_r;
    zm_nxt   = zm_r;
    srch_nxt = srch_r;
    res      = '0;
    res.status = ows_pkg::ST_IGN;

    pos    = POS_W'(bi_r - ONE);
    dir    = 1'b0;
    rom_t  = rom_r;
    zm_t   = zm_r;
    fm_t   = fm_r;
    done_t = done_r;

    unique case (stage.item.cmd)
      ows_pkg::CMD_RESET: begin
        rom_nxt  = '0;
        ld_nxt   = '0;
        fm_nxt   = '0;
        done_nxt = 1'b0;
        srch_nxt = 1'b0;
        bi_nxt   = ONE;
        zm_nxt   = '0;
        res.status = ows_pkg::ST_ACK;
      end
      ows_pkg::CMD_TARGET: begin
        rom_nxt  = ID_BITS'(target_family);
        ld_nxt   = LAST_POS;
        fm_nxt   = '0;
        done_nxt = 1'b0;
        srch_nxt = 1'b0;
        bi_nxt   = ONE;
        zm_nxt   = '0;
        res.status = ows_pkg::ST_ACK;
      end
      ows_pkg::CMD_BEGIN: begin
        bi_nxt = ONE;
        zm_nxt = '0;
        if (done_r || !stage.item.presence) begin
          srch_nxt = 1'b0;
          ld_nxt   = '0;
          fm_nxt   = '0;
          done_nxt = 1'b0;
          res.status = ows_pkg::ST_FAIL;
        end else begin
          srch_nxt = 1'b1;
          res.status = ows_pkg::ST_CMD;
          res.command_byte = stage.item.normal_search ? ows_pkg::SEARCH_NORMAL_BYTE
                                                      : ows_pkg::SEARCH_COND_BYTE;
        end
      end
      default: begin
        // Bit pair
        if (!srch_r) begin
          res.status = ows_pkg::ST_IGN;
        end else if (stage.item.id_bit && stage.item.complement_bit) begin
          // Nobody answered
          srch_nxt = 1'b0;
          ld_nxt   = '0;
          fm_nxt   = '0;
          done_nxt = 1'b0;
          res.status = ows_pkg::ST_FAIL;
        end else begin
          if (stage.item.id_bit != stage.item.complement_bit) begin
            dir = stage.item.id_bit;
          end else begin
            // Discrepancy: follow the previous path, or branch
            if (bi_r < ld_r) begin
              dir = rom_r[pos];
            end else begin
              dir = (bi_r == ld_r);
            end
            if (!dir) begin
              zm_t = bi_r;
              if (bi_r < ows_pkg::FAMILY_LIMIT) begin
                fm_t = bi_r;
              end
            end
          end
          rom_t[pos] = dir;
          rom_nxt    = rom_t;
          zm_nxt     = zm_t;
          fm_nxt     = fm_t;
          res.write_valid   = 1'b1;
          res.direction_bit = dir;
          res.status        = ows_pkg::ST_WRITE;

          if (bi_r >= LAST_POS) begin
            // Last id bit: close the pass
            srch_nxt = 1'b0;
            bi_nxt   = ONE;
            zm_nxt   = '0;
            ld_nxt   = zm_t;
            if (zm_t == '0) begin
              done_t = 1'b1;
            end
            done_nxt = done_t;
            if (rom_t[7:0] == 8'h00) begin
              ld_nxt   = '0;
              fm_nxt   = '0;
              done_nxt = 1'b0;
              res.status = ows_pkg::ST_FAIL;
            end else begin
              res.status             = ows_pkg::ST_FOUND;
              res.rom_id             = ows_pkg::ROM_W'(rom_t);
              res.last_device        = done_t;
              res.family_discrepancy = fm_t;
            end
          end else begin
            bi_nxt = bi_r + ONE;
          end
        end
      end
    endcase
  end

  // Enumeration state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_r  <= '0;
      ld_r   <= '0;
      fm_r   <= '0;
      done_r <= 1'b0;
      bi_r   <= ONE;
      zm_r   <= '0;
      srch_r <= 1'b0;
    end else if (fire) begin
      rom_r  <= rom_nxt;
      ld_r   <= ld_nxt;
      fm_r   <= fm_nxt;
      done_r <= done_nxt;
      bi_r   <= bi_nxt;
      zm_r   <= zm_nxt;
      srch_r <= srch_nxt;
    end
  end

endmodule

/* hdl/ows_out_reg.sv */
// Result register: holds one result until the receiver takes it.
module ows_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  ows_pkg::out_item_t res,
  output logic               out_free,
  output logic               out_valid,
  input  logic               out_ready,
  output ows_pkg::out_item_t out_item
);

  logic               valid_r;
  ows_pkg::out_item_t item_r;

  assign out_free  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= load;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= res;
    end
  end

endmodule

/* hdl/one_wire_rom_search.sv */
// One-wire ROM search engine, top level.
//
// Usage: each transfer on in_ch is one search step: begin (presence and
// search type), bit pair (id bit and complement), reset search or target
// search. Every step gives exactly one result on out_ch: the command byte
// to send, the direction bit to write, found (with ROM, last-device flag
// and family discrepancy), failed, acknowledged or ignored.
// cfg_we/cfg_wdata write the target family code; write it only while idle.
//
// An input transfer is registered in the input register, then passes through the step
// logic into the result register, from which it appears on out_ch. Throughput is one
// step per cycle while the receiver does not stall; the state update of a step is a
// single compare-and-select on the bit counters plus one ROM bit write, registered
// when the step is taken, so the next step uses it.
// When the receiver stalls, the result register holds its result; the input register
// takes one more step only if it is empty, and after that in_ch.ready drops.
// Reset (synchronous, rst_n low) empties both registers, clears the ROM,
// the discrepancy counters and the last-device flag, and sets the target
// family to 45.
module one_wire_rom_search #(
  parameter int unsigned ID_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  ows_in_if.sink      in_ch,
  ows_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  logic               tf_r;
  logic [7:0]         target_family_r;
  ows_pkg::in_item_t  in_item;
  ows_pkg::stage_t    stage;
  ows_pkg::out_item_t res;
  ows_pkg::out_item_t out_item;
  logic               fire;
  logic               out_free;

  // Target family register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_family_r <= ows_pkg::TARGET_FAMILY_RST;
    end else if (cfg_we) begin
      target_family_r <= cfg_wdata;
    end
  end

  // Low through reset and the first cycle after it, then high; masks the checks below
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tf_r <= 1'b0;
    end else begin
      tf_r <= 1'b1;
    end
  end

  assign in_item = '{cmd:            in_ch.cmd,
                     presence:       in_ch.presence,
                     normal_search:  in_ch.normal_search,
                     id_bit:         in_ch.id_bit,
                     complement_bit: in_ch.complement_bit};

  ows_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_item  (in_item),
    .in_ready (in_ch.ready),
    .take     (fire),
    .stage    (stage)
  );

  ows_core #(.ID_BITS(ID_BITS)) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .stage         (stage),
    .out_free      (out_free),
    .target_family (target_family_r),
    .fire          (fire),
    .res           (res)
  );

  ows_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  assign out_ch.status             = out_item.status;
  assign out_ch.write_valid        = out_item.write_valid;
  assign out_ch.direction_bit      = out_item.direction_bit;
  assign out_ch.command_byte       = out_item.command_byte;
  assign out_ch.rom_id             = out_item.rom_id;
  assign out_ch.last_device        = out_item.last_device;
  assign out_ch.family_discrepancy = out_item.family_discrepancy;

  // A step taken by the core always lands in the result register
  a_fire_loads: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_ch.valid)
    else $error("step taken but no result registered");

  // A found ROM never has a zero family byte
  a_found_family: assert property (@(posedge clk) disable iff (!rst_n || !tf_r)
    (out_ch.valid && out_ch.status == ows_pkg::ST_FOUND) |-> (out_ch.rom_id[7:0] != 8'h00))
    else $error("found ROM with zero family byte");

  // A direction write only comes with a bit-pair outcome
  a_write_status: assert property (@(posedge clk) disable iff (!rst_n || !tf_r)
    (out_ch.valid && out_ch.write_valid) |->
      (out_ch.status == ows_pkg::ST_WRITE || out_ch.status == ows_pkg::ST_FOUND ||
       out_ch.status == ows_pkg::ST_FAIL))
    else $error("direction write with wrong status");

  // A command byte is only given with the send-command status
  a_cmd_byte: assert property (@(posedge clk) disable iff (!rst_n || !tf_r)
    (out_ch.valid && out_ch.command_byte != 8'h00) |-> (out_ch.status == ows_pkg::ST_CMD))
    else $error("command byte outside send-command result");

endmodule

/* verif/one_wire_rom_search_checker.sv */
// Result checker for the ROM search engine: predicts each step's result and compares it.
module one_wire_rom_search_checker #(
  parameter int unsigned ID_BITS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  ows_in_if          in_mon,
  ows_out_if         out_mon,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  output int         fail_count,
  output int         pending
);

  // Predicted search state
  logic [7:0]                target_fam_q;
  logic [ows_pkg::ROM_W-1:0] rom_bits;
  logic [ows_pkg::CNT_W-1:0] last_disc_q;
  logic [ows_pkg::CNT_W-1:0] family_disc_q;
  logic                      done_q;
  logic [ows_pkg::CNT_W-1:0] bit_pos;
  logic [ows_pkg::CNT_W-1:0] zero_pos;
  logic                      in_pass;

  ows_pkg::out_item_t expected_results[$];
  int                 mismatches = 0;
  int                 results_seen = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
             results_seen, what, got, want);
    mismatches++;
  endtask

  function automatic void clear_discrepancies();
    last_disc_q   = '0;
    family_disc_q = '0;
    done_q        = 1'b0;
  endfunction

  // One search step: updates the predicted state and returns the result it gives
  function automatic ows_pkg::out_item_t search_step(input ows_pkg::in_item_t it);
    ows_pkg::out_item_t r;
    logic               dir;
    logic [5:0]         pos;
    r = '0;
    case (it.cmd)
      ows_pkg::CMD_RESET: begin
        rom_bits = '0;
        clear_discrepancies();
        in_pass  = 1'b0;
        bit_pos  = 7'd1;
        zero_pos = '0;
        r.status = ows_pkg::ST_ACK;
      end
      ows_pkg::CMD_TARGET: begin
        rom_bits = {56'd0, target_fam_q};
        clear_discrepancies();
        last_disc_q = 7'(ID_BITS);
        in_pass     = 1'b0;
        bit_pos     = 7'd1;
        zero_pos    = '0;
        r.status    = ows_pkg::ST_ACK;
      end
      ows_pkg::CMD_BEGIN: begin
        in_pass  = 1'b0;
        bit_pos  = 7'd1;
        zero_pos = '0;
        if (done_q || !it.presence) begin
          clear_discrepancies();
          r.status = ows_pkg::ST_FAIL;
        end else begin
          in_pass        = 1'b1;
          r.status       = ows_pkg::ST_CMD;
          r.command_byte = it.normal_search ? ows_pkg::SEARCH_NORMAL_BYTE
                                            : ows_pkg::SEARCH_COND_BYTE;
        end
      end
      default: begin
        if (!in_pass) begin
          r.status = ows_pkg::ST_IGN;
        end else if (it.id_bit && it.complement_bit) begin
          // nobody answered the slot
          in_pass = 1'b0;
          clear_discrepancies();
          r.status = ows_pkg::ST_FAIL;
        end else begin
          pos = 6'(bit_pos - 7'd1);
          if (it.id_bit != it.complement_bit) begin
            dir = it.id_bit;
          end else begin
            // discrepancy: follow the previous path, turn at the last branch
            if (bit_pos < last_disc_q) dir = rom_bits[pos];
            else dir = (bit_pos == last_disc_q);
            if (!dir) begin
              zero_pos = bit_pos;
              if (zero_pos < ows_pkg::FAMILY_LIMIT) family_disc_q = zero_pos;
            end
          end
          rom_bits[pos]   = dir;
          r.write_valid   = 1'b1;
          r.direction_bit = dir;
          r.status        = ows_pkg::ST_WRITE;
          if (bit_pos >= ID_BITS) begin
            in_pass     = 1'b0;
            bit_pos     = 7'd1;
            last_disc_q = zero_pos;
            if (last_disc_q == '0) done_q = 1'b1;
            if (rom_bits[7:0] == 8'd0) begin
              clear_discrepancies();
              r.status = ows_pkg::ST_FAIL;
            end else begin
              r.status             = ows_pkg::ST_FOUND;
              r.rom_id             = rom_bits;
              r.last_device        = done_q;
              r.family_discrepancy = family_disc_q;
            end
            zero_pos = '0;
          end else begin
            bit_pos = bit_pos + 7'd1;
          end
        end
      end
    endcase
    return r;
  endfunction

  // Compare results on their transfer, predict on each input transfer
  always @(posedge clk) begin : watch
    ows_pkg::in_item_t  step;
    ows_pkg::out_item_t want;
    if (!rst_n) begin
      target_fam_q  = ows_pkg::TARGET_FAMILY_RST;
      rom_bits      = '0;
      clear_discrepancies();
      bit_pos       = 7'd1;
      zero_pos      = '0;
      in_pass       = 1'b0;
      expected_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("arrived with nothing predicted, status",
                          64'(out_mon.status), '0);
        end else begin
          want = expected_results.pop_front();
          if (out_mon.status !== want.status)
            report_mismatch("status", 64'(out_mon.status), 64'(want.status));
          if (out_mon.write_valid !== want.write_valid)
            report_mismatch("write_valid", 64'(out_mon.write_valid),
                            64'(want.write_valid));
          if (out_mon.direction_bit !== want.direction_bit)
            report_mismatch("direction_bit", 64'(out_mon.direction_bit),
                            64'(want.direction_bit));
          if (out_mon.command_byte !== want.command_byte)
            report_mismatch("command_byte", 64'(out_mon.command_byte),
                            64'(want.command_byte));
          if (out_mon.rom_id !== want.rom_id)
            report_mismatch("rom_id", out_mon.rom_id, want.rom_id);
          if (out_mon.last_device !== want.last_device)
            report_mismatch("last_device", 64'(out_mon.last_device),
                            64'(want.last_device));
          if (out_mon.family_discrepancy !== want.family_discrepancy)
            report_mismatch("family_discrepancy", 64'(out_mon.family_discrepancy),
                            64'(want.family_discrepancy));
        end
      end
      if (cfg_we) target_fam_q = cfg_wdata;
      if (in_mon.valid && in_mon.ready) begin
        step.cmd            = in_mon.cmd;
        step.presence       = in_mon.presence;
        step.normal_search  = in_mon.normal_search;
        step.id_bit         = in_mon.id_bit;
        step.complement_bit = in_mon.complement_bit;
        expected_results.push_back(search_step(step));
      end
    end
    pending    <= expected_results.size();
    fail_count <= mismatches;
  end

endmodule

/* verif/one_wire_rom_search_tb.sv */
// Testbench top for the ROM search engine: clock, reset, stimulus and verdict.
module one_wire_rom_search_tb;

  localparam int unsigned ID_BITS        = 64;
  localparam int          ITEMS          = 1200;
  localparam int          PHASES         = 5;
  localparam int          WATCHDOG_LIMIT = 2000;

  // Shapes of a search pass
  typedef enum int {
    PASS_FREE,
    PASS_ZERO_FAMILY,
    PASS_ALL_ONES
  } pass_shape_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  logic       calm;
  int         fail_count;
  int         pending;
  int         steps_sent;
  int         stall_cycles;

  ows_in_if  in_ch ();
  ows_out_if out_ch ();

  one_wire_rom_search #(
    .ID_BITS (ID_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  one_wire_rom_search_checker #(
    .ID_BITS (ID_BITS)
  ) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: drops ready at random, about 14 percent of the time, unless calm
  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 14);
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  function automatic ows_pkg::in_item_t begin_item(input logic pres, input logic norm);
    ows_pkg::in_item_t it;
    it.cmd            = ows_pkg::CMD_BEGIN;
    it.presence       = pres;
    it.normal_search  = norm;
    it.id_bit         = 1'($urandom_range(1));
    it.complement_bit = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic ows_pkg::in_item_t pair_item(input logic id, input logic cmp);
    ows_pkg::in_item_t it;
    it.cmd            = ows_pkg::CMD_PAIR;
    it.presence       = 1'($urandom_range(1));
    it.normal_search  = 1'($urandom_range(1));
    it.id_bit         = id;
    it.complement_bit = cmp;
    return it;
  endfunction

  function automatic ows_pkg::in_item_t ctl_item(input ows_pkg::cmd_t c);
    ows_pkg::in_item_t it;
    it.cmd            = c;
    it.presence       = 1'($urandom_range(1));
    it.normal_search  = 1'($urandom_range(1));
    it.id_bit         = 1'($urandom_range(1));
    it.complement_bit = 1'($urandom_range(1));
    return it;
  endfunction

  // Drive one step and hold it until its transfer
  task automatic send(input ows_pkg::in_item_t it);
    if (!calm && $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.cmd            <= it.cmd;
    in_ch.presence       <= it.presence;
    in_ch.normal_search  <= it.normal_search;
    in_ch.id_bit         <= it.id_bit;
    in_ch.complement_bit <= it.complement_bit;
    do @(posedge clk); while (!in_ch.ready);
    steps_sent++;
  endtask

  // Stop sending and wait until every predicted result has come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_family(input logic [7:0] code);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= code;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Begin plus one pair per id bit; stop_at > 0 breaks the pass at that bit
  task automatic run_pass(input int split_pct, input int stop_at, input pass_shape_t shape);
    int   b;
    bit   cut;
    logic id;
    send(begin_item(1'b1, 1'($urandom_range(1))));
    cut = 1'b0;
    b   = 1;
    while (b <= ID_BITS && !cut) begin
      if (b == stop_at) begin
        cut = 1'b1;
        case ($urandom_range(4))
          0: send(pair_item(1'b1, 1'b1));
          1: send(begin_item(1'($urandom_range(1)), 1'($urandom_range(1))));
          2: send(ctl_item(ows_pkg::CMD_RESET));
          3: send(ctl_item(ows_pkg::CMD_TARGET));
          default: ; // pass simply abandoned
        endcase
      end else if (shape == PASS_ALL_ONES) begin
        send(pair_item(1'b1, 1'b0));
      end else if (shape == PASS_ZERO_FAMILY && b <= 8) begin
        send(pair_item(1'b0, 1'b1));
      end else if ($urandom_range(99) < split_pct) begin
        send(pair_item(1'b0, 1'b0));
      end else begin
        id = 1'($urandom_range(1));
        send(pair_item(id, ~id));
      end
      b++;
    end
  endtask

  // Main stimulus
  initial begin : stimulus
    int                ph;
    int                r;
    int                split;
    int                stop_at;
    int                phase_end;
    pass_shape_t       shape;
    logic [7:0]        fam;
    ows_pkg::in_item_t it;

    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = 8'd0;
    calm                 = 1'b0;
    steps_sent           = 0;
    stall_cycles         = 0;
    in_ch.valid          = 1'b0;
    in_ch.cmd            = ows_pkg::CMD_RESET;
    in_ch.presence       = 1'b0;
    in_ch.normal_search  = 1'b0;
    in_ch.id_bit         = 1'b0;
    in_ch.complement_bit = 1'b0;
    out_ch.ready         = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    write_family(8'h28);

    // Directed: ignored pairs, no presence, both command bytes, restart, empty bus
    send(pair_item(1'b1, 1'b0));
    send(begin_item(1'b0, 1'b1));
    send(ctl_item(ows_pkg::CMD_RESET));
    send(begin_item(1'b1, 1'b0));
    send(pair_item(1'b0, 1'b0));
    send(pair_item(1'b1, 1'b0));
    send(begin_item(1'b1, 1'b1));
    send(pair_item(1'b0, 1'b1));
    send(pair_item(1'b1, 1'b1));
    send(pair_item(1'b0, 1'b1));
    send(ctl_item(ows_pkg::CMD_TARGET));
    send(begin_item(1'b0, 1'b0));

    // Whole passes: last device, begin after it, target family, zero family byte
    run_pass(0, 0, PASS_ALL_ONES);
    send(begin_item(1'b1, 1'b1));
    send(ctl_item(ows_pkg::CMD_TARGET));
    run_pass(100, 0, PASS_FREE);
    run_pass(0, 0, PASS_ZERO_FAMILY);

    // Random phases, each under its own family code
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       fam = 8'h00;
        1:       fam = 8'hFF;
        2:       fam = 8'h01;
        3:       fam = 8'h80;
        default: fam = 8'($urandom_range(255));
      endcase
      write_family(fam);
      calm      = (ph == 3);
      phase_end = ITEMS * (ph + 1) / PHASES;
      while (steps_sent < phase_end) begin
        r = $urandom_range(99);
        if (r < 70) begin
          case ($urandom_range(3))
            0:       split = 0;
            1:       split = 3;
            2:       split = 15;
            default: split = 50;
          endcase
          stop_at = ($urandom_range(99) < 20) ? $urandom_range(1, ID_BITS) : 0;
          r = $urandom_range(99);
          if (r < 5) shape = PASS_ZERO_FAMILY;
          else if (r < 10) shape = PASS_ALL_ONES;
          else shape = PASS_FREE;
          run_pass(split, stop_at, shape);
        end else if (r < 78) begin
          send(ctl_item(ows_pkg::CMD_RESET));
        end else if (r < 86) begin
          send(ctl_item(ows_pkg::CMD_TARGET));
        end else begin
          // noise: fully random steps
          repeat ($urandom_range(1, 4)) begin
            it.cmd            = ows_pkg::cmd_t'(2'($urandom_range(3)));
            it.presence       = 1'($urandom_range(1));
            it.normal_search  = 1'($urandom_range(1));
            it.id_bit         = 1'($urandom_range(1));
            it.complement_bit = 1'($urandom_range(1));
            send(it);
          end
        end
      end
    end
    calm = 1'b0;

    drain();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
